>>> src/best_fit_bin_packer_macros.svh
// Assertion macros used by the best-fit bin packer datapath.
`ifndef BEST_FIT_BIN_PACKER_MACROS_SVH
`define BEST_FIT_BIN_PACKER_MACROS_SVH

// Condition that must hold on every clock edge out of reset.
`define BFBP_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Same-cycle implication.
`define BFBP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BFBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/bfbp_pkg.sv
// Shared types, constants and helpers for the best-fit bin packer.
package bfbp_pkg;

    localparam int SIZE_W    = 17;
    localparam int FREE_W    = 16;
    localparam int BIN_NUM_W = 7;

    // One whole bin in 1/65536 units.
    localparam logic [SIZE_W-1:0] BIN_CAP = 17'h10000;

    typedef logic [SIZE_W-1:0] t_size;
    typedef logic [FREE_W-1:0] t_free;

    typedef struct packed {
        logic load;     // capture a new item
        logic read;     // issue one table read of the scan
        logic commit;   // place the item and load the result register
    } t_cmd;

    typedef struct packed {
        logic reads_done;   // every open bin has been read
        logic out_free;     // result register can take a new item
    } t_stat;

    // Zero counts as the smallest size; anything over one bin is one bin.
    function automatic t_size sat_size(input t_size s);
        t_size r;
        if (s == '0) begin
            r = t_size'(1);
        end else if (s > BIN_CAP) begin
            r = BIN_CAP;
        end else begin
            r = s;
        end
        return r;
    endfunction

endpackage

>>> src/best_fit_bin_packer.sv
// Best-fit bin packer, top level.
// Online best-fit bin packing over a table of MAX_BINS bins. Each input item
// (size in 1/65536 of a bin, flag to start a new run) goes into the open bin
// with the least free space that still holds it, lowest bin on ties; if none
// fits a new bin is opened, and if all bins are open the result flags table
// full and nothing changes. One item at a time: the scan reads one bin table
// entry per cycle from a single-port memory, the placement is then committed
// into the result register, and only then is the next item accepted. A
// finished result waits in an output register, so the next item is accepted
// while it waits; a second result stalls until the first is taken. Sizes of
// 0 count as 1, sizes above one bin count as one bin. Bin numbers start at
// 1 and wrap at 128.
module best_fit_bin_packer #(
    parameter int MAX_BINS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [16:0] item_size
    input  logic [0:0]  s_axis_tuser,   // [0] first_item
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [6:0] bin_number, [22:7] space_left
    output logic [1:0]  m_axis_tuser    // [0] opened_new, [1] table_full
);
    import bfbp_pkg::*;

    t_cmd                 cmd;
    t_stat                stat;
    logic [BIN_NUM_W-1:0] bin_number;
    logic                 opened_new;
    t_free                space_left;
    logic                 table_full;

    bfbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bfbp_dpath #(
        .MAX_BINS (MAX_BINS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_item_size  (s_axis_tdata[SIZE_W-1:0]),
        .i_first_item (s_axis_tuser[0]),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_bin_number (bin_number),
        .o_opened_new (opened_new),
        .o_space_left (space_left),
        .o_table_full (table_full)
    );

    assign m_axis_tdata = {1'b0, space_left, bin_number};
    assign m_axis_tuser = {table_full, opened_new};

endmodule

>>> src/bfbp_ctrl.sv
// Sequencer: accept, scan the open bins, then commit the placement.
module bfbp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  bfbp_pkg::t_stat  i_stat,
    output bfbp_pkg::t_cmd   o_cmd
);
    import bfbp_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                // last read's data is compared in the cycle reads_done shows
                if (!i_stat.reads_done) begin
                    o_cmd.read = 1'b1;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> src/bfbp_dpath.sv
// Bin table, tightest-fit scan datapath and result register.
`include "best_fit_bin_packer_macros.svh"

module bfbp_dpath #(
    parameter int MAX_BINS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bfbp_pkg::t_cmd                   i_cmd,
    output bfbp_pkg::t_stat                  o_stat,
    input  bfbp_pkg::t_size                  i_item_size,
    input  logic                             i_first_item,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [bfbp_pkg::BIN_NUM_W-1:0]   o_bin_number,
    output logic                             o_opened_new,
    output bfbp_pkg::t_free                  o_space_left,
    output logic                             o_table_full
);
    import bfbp_pkg::*;

    localparam int IW = $clog2(MAX_BINS);
    localparam int CW = $clog2(MAX_BINS + 1);
    localparam int NW = (CW > BIN_NUM_W) ? CW : BIN_NUM_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BINS);

    t_free            r_mem [MAX_BINS];
    t_free            r_rd_data;
    logic             r_rd_valid;
    logic [IW-1:0]    r_rd_tag;
    logic [CW-1:0]    r_rd_idx;
    logic [CW-1:0]    r_bins_open;
    t_size            r_size;
    logic             r_found;
    logic [IW-1:0]    r_best;
    t_free            r_best_free;

    logic             r_out_valid;
    logic [BIN_NUM_W-1:0] r_out_bin;
    logic             r_out_new;
    t_free            r_out_space;
    logic             r_out_full;

    logic             hit;
    logic             can_open;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    t_free            wr_data;
    t_free            fit_free;
    t_size            cap_diff;
    logic [NW-1:0]    bin_wide;

    always_comb begin
        hit = r_rd_valid && ({1'b0, r_rd_data} >= r_size)
              && (!r_found || (r_rd_data < r_best_free));
        can_open = (r_bins_open != MAX_CNT);
        // a fitting bin has free >= size, so size fits in 16 bits there
        fit_free = r_best_free - r_size[FREE_W-1:0];
        cap_diff = BIN_CAP - r_size;
        wr_en    = i_cmd.commit && (r_found || can_open);
        wr_addr  = r_found ? r_best : r_bins_open[IW-1:0];
        wr_data  = r_found ? fit_free : cap_diff[FREE_W-1:0];
        bin_wide = NW'(wr_addr) + NW'(1);
        o_stat.reads_done = (r_rd_idx == r_bins_open);
        o_stat.out_free   = !r_out_valid || i_ready;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.read) begin
            r_rd_data <= r_mem[r_rd_idx[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_tag <= r_rd_idx[IW-1:0];
        end
        if (i_cmd.load) begin
            r_size <= sat_size(i_item_size);
        end
        if (hit) begin
            r_best      <= r_rd_tag;
            r_best_free <= r_rd_data;
        end
        if (i_cmd.commit) begin
            r_out_bin   <= (wr_en) ? bin_wide[BIN_NUM_W-1:0] : '0;
            r_out_new   <= !r_found && can_open;
            r_out_space <= (wr_en) ? wr_data : '0;
            r_out_full  <= !wr_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid  <= 1'b0;
            r_rd_idx    <= '0;
            r_bins_open <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.read;
            if (i_cmd.load) begin
                r_rd_idx <= '0;
                r_found  <= 1'b0;
                if (i_first_item) begin
                    r_bins_open <= '0;
                end
            end else if (i_cmd.read) begin
                r_rd_idx <= r_rd_idx + CW'(1);
            end
            if (hit) begin
                r_found <= 1'b1;
            end
            if (i_cmd.commit && !r_found && can_open) begin
                r_bins_open <= r_bins_open + CW'(1);
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_bin_number = r_out_bin;
    assign o_opened_new = r_out_new;
    assign o_space_left = r_out_space;
    assign o_table_full = r_out_full;

    `BFBP_ASSERT_ALWAYS(a_open_bound, i_clk, i_rst_n, r_bins_open <= MAX_CNT, "bin count over limit")
    `BFBP_ASSERT_IMPL(a_no_overread, i_clk, i_rst_n, i_cmd.read, !o_stat.reads_done, "read past open bins")
    `BFBP_ASSERT_IMPL(a_commit_settled, i_clk, i_rst_n, i_cmd.commit, !r_rd_valid, "commit with compare pending")
    `BFBP_ASSERT_NEXT(a_full_result, i_clk, i_rst_n, i_cmd.commit && !r_found && !can_open, o_valid && o_table_full && (o_bin_number == '0), "table full not reported")

endmodule
